[hw/rtl/sjac_pkg.sv]
// sjac_pkg: shared constants, command codes and transaction types of the
// sorted-set jaccard unit. No dependencies; imported by every rtl file.
`timescale 1ns / 1ps
`default_nettype none

package sjac_pkg;

  // list capacity and ratio precision
  localparam int unsigned LIST_DEPTH    = 256;
  localparam int unsigned FRACTION_BITS = 16;

  // derived widths
  localparam int unsigned ELEM_W  = 31;
  localparam int unsigned IDX_W   = $clog2(LIST_DEPTH);
  localparam int unsigned COUNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned UNION_W = COUNT_W + 1;
  localparam int unsigned JAC_W   = FRACTION_BITS + 1;
  localparam int unsigned NUM_W   = COUNT_W + FRACTION_BITS;
  localparam int unsigned STEP_W  = $clog2(NUM_W + 1);

  // command codes
  typedef enum logic [1:0] {
    CMD_FIRST   = 2'd0,
    CMD_SECOND  = 2'd1,
    CMD_COMPUTE = 2'd2
  } sjac_cmd_e;

  // input transaction
  typedef struct packed {
    logic [1:0]        cmd;
    logic [ELEM_W-1:0] element;
  } sjac_item_t;

  // result transaction
  typedef struct packed {
    logic [COUNT_W-1:0] common_count;
    logic [COUNT_W-1:0] first_size;
    logic [COUNT_W-1:0] second_size;
    logic [UNION_W-1:0] union_size;
    logic [JAC_W-1:0]   jaccard;
    logic               order_error;
    logic               overflow_error;
  } sjac_result_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   numer;
    logic [UNION_W-1:0] denom;
  } sjac_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } sjac_div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/sjac_divider.sv]
// sjac_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on sjac_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module sjac_divider
  import sjac_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sjac_div_req_t req_i,
  output sjac_div_rsp_t      rsp_o
);

  logic [NUM_W-1:0]   shift_q, shift_d;
  logic [UNION_W-1:0] rem_q, rem_d;
  logic [UNION_W-1:0] den_q, den_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [UNION_W:0]   trial;
  logic [UNION_W:0]   diff;

  // one shift-subtract step: numerator bits leave at the top, quotient
  // bits enter at the bottom
  always_comb begin
    trial   = {rem_q, shift_q[NUM_W-1]};
    diff    = trial - {1'b0, den_q};
    shift_d = shift_q;
    rem_d   = rem_q;
    den_d   = den_q;
    step_d  = step_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      shift_d = req_i.numer;
      rem_d   = '0;
      den_d   = req_i.denom;
      step_d  = STEP_W'(NUM_W);
      run_d   = 1'b1;
    end else if (run_q) begin
      if (!diff[UNION_W]) begin
        rem_d   = diff[UNION_W-1:0];
        shift_d = {shift_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d   = trial[UNION_W-1:0];
        shift_d = {shift_q[NUM_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = shift_q;

endmodule

`default_nettype wire

[hw/rtl/sorted_set_jaccard_unit.sv]
// sorted_set_jaccard_unit: two ascending id lists, merge-walk intersection
// and a fixed-point jaccard ratio. Depends on sjac_pkg and sjac_divider.
//
//   channel   ports                      handshake
//   --------  -------------------------  -------------------------------
//   command   item_i                     start_i high while busy_o low
//   result    result_o                   result_valid_o, one-cycle strobe
//
// An append gives no result. A compute walks both lists one merge step a
// cycle through 31-bit comparators, then the bit-serial divider forms the
// ratio; the result strobe follows the division, or the walk directly when
// the union is empty. busy_o is high for the whole compute. Reset clears
// counts, last ids and flags; list memories need no clearing. The receiver
// cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_jaccard_unit
  import sjac_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire sjac_item_t item_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output sjac_result_t    result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ELEM_W-1:0]  first_mem  [LIST_DEPTH];
  logic [ELEM_W-1:0]  second_mem [LIST_DEPTH];
  logic [ELEM_W-1:0]  first_rd_q, second_rd_q;

  logic [COUNT_W-1:0] first_cnt_q, first_cnt_d;
  logic [COUNT_W-1:0] second_cnt_q, second_cnt_d;
  logic [ELEM_W-1:0]  first_last_q, first_last_d;
  logic [ELEM_W-1:0]  second_last_q, second_last_d;
  logic               order_q, order_d;
  logic               overflow_q, overflow_d;
  logic [COUNT_W-1:0] a_q, a_d;
  logic [COUNT_W-1:0] b_q, b_d;
  logic [COUNT_W-1:0] common_q, common_d;
  logic               valid_q, valid_d;
  sjac_result_t       result_q, result_d;

  logic               accept;
  logic               first_we, second_we;
  logic [UNION_W-1:0] union_size;
  logic               walk_end;
  sjac_div_req_t      div_req;
  sjac_div_rsp_t      div_rsp;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign union_size = {1'b0, first_cnt_q} + {1'b0, second_cnt_q} - {1'b0, common_q};
  assign walk_end   = (a_q >= first_cnt_q) || (b_q >= second_cnt_q);

  // sequencer: appends, merge walk, division and result capture
  always_comb begin
    state_d       = state_q;
    first_cnt_d   = first_cnt_q;
    second_cnt_d  = second_cnt_q;
    first_last_d  = first_last_q;
    second_last_d = second_last_q;
    order_d       = order_q;
    overflow_d    = overflow_q;
    a_d           = a_q;
    b_d           = b_q;
    common_d      = common_q;
    valid_d       = 1'b0;
    result_d      = result_q;
    first_we      = 1'b0;
    second_we     = 1'b0;
    div_req.start = 1'b0;
    div_req.numer = {common_q, {FRACTION_BITS{1'b0}}};
    div_req.denom = union_size;

    // result fields that do not depend on the ratio
    result_d.common_count   = common_q;
    result_d.first_size     = first_cnt_q;
    result_d.second_size    = second_cnt_q;
    result_d.union_size     = union_size;
    result_d.order_error    = order_q;
    result_d.overflow_error = overflow_q;
    result_d.jaccard        = result_q.jaccard;

    case (state_q)
      ST_IDLE: begin
        a_d = '0;
        b_d = '0;
        if (accept) begin
          case (item_i.cmd)
            CMD_FIRST: begin
              if (first_cnt_q >= COUNT_W'(LIST_DEPTH)) begin
                overflow_d = 1'b1;
              end else if ((first_cnt_q != '0) && (item_i.element <= first_last_q)) begin
                order_d = 1'b1;
              end else begin
                first_we     = 1'b1;
                first_cnt_d  = first_cnt_q + COUNT_W'(1);
                first_last_d = item_i.element;
              end
            end
            CMD_SECOND: begin
              if (second_cnt_q >= COUNT_W'(LIST_DEPTH)) begin
                overflow_d = 1'b1;
              end else if ((second_cnt_q != '0) && (item_i.element <= second_last_q)) begin
                order_d = 1'b1;
              end else begin
                second_we     = 1'b1;
                second_cnt_d  = second_cnt_q + COUNT_W'(1);
                second_last_d = item_i.element;
              end
            end
            CMD_COMPUTE: begin
              common_d = '0;
              state_d  = ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (walk_end) begin
          if (union_size == '0) begin
            result_d.jaccard = '0;
            valid_d          = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end
        end else if (first_rd_q < second_rd_q) begin
          a_d = a_q + COUNT_W'(1);
        end else if (second_rd_q < first_rd_q) begin
          b_d = b_q + COUNT_W'(1);
        end else begin
          a_d      = a_q + COUNT_W'(1);
          b_d      = b_q + COUNT_W'(1);
          common_d = common_q + COUNT_W'(1);
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          result_d.jaccard = div_rsp.quot[JAC_W-1:0];
          valid_d          = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a delivered result clears both lists and flags
    if (valid_d) begin
      first_cnt_d   = '0;
      second_cnt_d  = '0;
      first_last_d  = '0;
      second_last_d = '0;
      order_d       = 1'b0;
      overflow_d    = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      first_cnt_q   <= '0;
      second_cnt_q  <= '0;
      first_last_q  <= '0;
      second_last_q <= '0;
      order_q       <= 1'b0;
      overflow_q    <= 1'b0;
      a_q           <= '0;
      b_q           <= '0;
      common_q      <= '0;
      valid_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      first_cnt_q   <= first_cnt_d;
      second_cnt_q  <= second_cnt_d;
      first_last_q  <= first_last_d;
      second_last_q <= second_last_d;
      order_q       <= order_d;
      overflow_q    <= overflow_d;
      a_q           <= a_d;
      b_q           <= b_d;
      common_q      <= common_d;
      valid_q       <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // list memories: one write port, one registered read at the next walk index
  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[first_cnt_q[IDX_W-1:0]] <= item_i.element;
    end
    first_rd_q <= first_mem[a_d[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (second_we) begin
      second_mem[second_cnt_q[IDX_W-1:0]] <= item_i.element;
    end
    second_rd_q <= second_mem[b_d[IDX_W-1:0]];
  end

  // bit-serial divider for the ratio
  sjac_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire
